[hw/rtl/tcsm_pkg.sv]
`timescale 1ns / 1ps
// Package for the TCP connection state machine: state codes, flag bits,
// item and event structs. No dependencies.
package tcsm_pkg;

   localparam int SEQ_FIELD_W  = 32;
   localparam int FLAG_W       = 6;
   localparam int WND_W        = 16;
   localparam int STATE_W      = 4;
   localparam int REQ_TDATA_W  = 128;
   localparam int RSP_TDATA_W  = 80;

   typedef enum logic [STATE_W-1:0] {
      ST_CLOSED     = 4'd0,
      ST_LISTEN     = 4'd1,
      ST_SYN_RECV   = 4'd2,
      ST_SYN_SENT   = 4'd3,
      ST_ESTAB      = 4'd4,
      ST_CLOSE_WAIT = 4'd5,
      ST_LAST_ACK   = 4'd6,
      ST_FIN_WAIT1  = 4'd7,
      ST_FIN_WAIT2  = 4'd8,
      ST_CLOSING    = 4'd9,
      ST_TIME_WAIT  = 4'd10
   } conn_state_type;

   localparam logic ACT_SEGMENT = 1'b0;
   localparam logic ACT_LOAD    = 1'b1;

   localparam int FL_FIN_BIT = 0;
   localparam int FL_SYN_BIT = 1;
   localparam int FL_RST_BIT = 2;
   localparam int FL_ACK_BIT = 4;

   localparam logic [FLAG_W-1:0] SEND_NONE    = 6'h00;
   localparam logic [FLAG_W-1:0] SEND_ACK     = 6'h10;
   localparam logic [FLAG_W-1:0] SEND_SYN_ACK = 6'h12;

   typedef struct packed {
      logic                   action;
      logic [FLAG_W-1:0]      seg_flags;
      logic [SEQ_FIELD_W-1:0] seg_seq;
      logic [SEQ_FIELD_W-1:0] seg_seq_end;
      logic [SEQ_FIELD_W-1:0] seg_ack;
      logic [WND_W-1:0]       recv_window;
      logic                   accept_full;
      logic [STATE_W-1:0]     load_state;
   } seg_item_type;

   typedef struct packed {
      logic [FLAG_W-1:0] send_flags;
      logic              dropped;
      logic              reset_seen;
      logic              spawn_child;
      logic              wake_waiter;
      logic              start_timewait;
      logic              released;
   } step_event_type;

endpackage

[hw/rtl/tcsm_in_reg.sv]
`timescale 1ns / 1ps
// Input register stage: holds one accepted request transfer until the
// step logic consumes it. Depends on tcsm_pkg.
module tcsm_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tcsm_pkg::seg_item_type req_item,
   input  logic                  take,
   output logic                  item_valid,
   output tcsm_pkg::seg_item_type item
);
   import tcsm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   seg_item_type item_ff;

   assign req_ready  = !valid_ff || take;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

[hw/rtl/tcsm_step.sv]
`timescale 1ns / 1ps
// One-pass resolution of a segment or load against the connection state:
// next state, next sequence values and event strobes. Depends on tcsm_pkg.
module tcsm_step #(
   parameter int SEQ_BITS = 32
) (
   input  tcsm_pkg::seg_item_type   item,
   input  tcsm_pkg::conn_state_type state,
   input  logic [SEQ_BITS-1:0]      rcv_next,
   input  logic [SEQ_BITS-1:0]      snd_unacked,
   output tcsm_pkg::conn_state_type state_in,
   output logic [SEQ_BITS-1:0]      rcv_next_in,
   output logic [SEQ_BITS-1:0]      snd_unacked_in,
   output tcsm_pkg::step_event_type events
);
   import tcsm_pkg::*;

   logic                is_load;
   logic                fl_fin;
   logic                fl_syn;
   logic                fl_rst;
   logic                fl_ack;
   logic [SEQ_BITS-1:0] seq;
   logic [SEQ_BITS-1:0] seq_end;
   logic [SEQ_BITS-1:0] ack;
   logic [SEQ_BITS-1:0] seq_inc;
   logic [SEQ_BITS-1:0] wnd_eff;
   logic [SEQ_BITS-1:0] rend;
   logic [SEQ_BITS-1:0] diff_lt;
   logic [SEQ_BITS-1:0] diff_le;
   logic                in_window;

   assign is_load = (item.action == ACT_LOAD);
   assign fl_fin  = item.seg_flags[FL_FIN_BIT];
   assign fl_syn  = item.seg_flags[FL_SYN_BIT];
   assign fl_rst  = item.seg_flags[FL_RST_BIT];
   assign fl_ack  = item.seg_flags[FL_ACK_BIT];

   assign seq     = item.seg_seq[SEQ_BITS-1:0];
   assign seq_end = item.seg_seq_end[SEQ_BITS-1:0];
   assign ack     = item.seg_ack[SEQ_BITS-1:0];
   assign seq_inc = seq + SEQ_BITS'(1);

   // zero window counts as one byte
   assign wnd_eff = (item.recv_window == '0) ? SEQ_BITS'(1) : SEQ_BITS'(item.recv_window);
   assign rend    = rcv_next + wnd_eff;
   assign diff_lt = seq - rend;
   assign diff_le = rcv_next - seq_end;
   assign in_window = diff_lt[SEQ_BITS-1] && ((diff_le == '0) || diff_le[SEQ_BITS-1]);

   // next state
   always_comb begin
      state_in = state;
      priority if (is_load) begin
         state_in = (item.load_state > ST_TIME_WAIT) ? ST_CLOSED
                                                     : conn_state_type'(item.load_state);
      end else if (fl_rst) begin
         state_in = ST_CLOSED;
      end else begin
         unique case (state)
            ST_LISTEN: begin
               if (fl_syn) state_in = ST_SYN_RECV;
            end
            ST_SYN_SENT: begin
               if (fl_syn && fl_ack) state_in = ST_ESTAB;
            end
            ST_SYN_RECV: begin
               if (fl_ack && !item.accept_full) state_in = ST_ESTAB;
            end
            ST_ESTAB: begin
               if (in_window && fl_fin) state_in = ST_CLOSE_WAIT;
            end
            ST_LAST_ACK: begin
               if (in_window && fl_ack) state_in = ST_CLOSED;
            end
            ST_FIN_WAIT1: begin
               if (in_window && fl_ack) state_in = ST_FIN_WAIT2;
            end
            ST_FIN_WAIT2: begin
               if (in_window && fl_fin) state_in = ST_TIME_WAIT;
            end
            default: begin
            end
         endcase
      end
   end

   // sequence updates and strobes
   always_comb begin
      rcv_next_in    = rcv_next;
      snd_unacked_in = snd_unacked;
      events         = '0;
      events.send_flags = SEND_NONE;
      priority if (is_load) begin
         rcv_next_in    = seq;
         snd_unacked_in = ack;
      end else if (fl_rst) begin
         events.reset_seen = 1'b1;
      end else begin
         unique case (state)
            ST_LISTEN: begin
               if (fl_syn) begin
                  rcv_next_in        = seq_inc;
                  events.spawn_child = 1'b1;
                  events.send_flags  = SEND_SYN_ACK;
               end
            end
            ST_SYN_SENT: begin
               if (fl_syn && fl_ack) begin
                  rcv_next_in        = seq_inc;
                  snd_unacked_in     = ack;
                  events.wake_waiter = 1'b1;
                  events.send_flags  = SEND_ACK;
               end
            end
            ST_SYN_RECV: begin
               if (fl_ack && !item.accept_full) begin
                  rcv_next_in        = seq;
                  snd_unacked_in     = ack;
                  events.wake_waiter = 1'b1;
               end
            end
            default: begin
               events.dropped = !in_window;
               if (in_window) begin
                  unique case (state)
                     ST_ESTAB: begin
                        if (fl_fin) begin
                           rcv_next_in       = seq_inc;
                           snd_unacked_in    = ack;
                           events.send_flags = SEND_ACK;
                        end
                     end
                     ST_LAST_ACK: begin
                        if (fl_ack) begin
                           rcv_next_in     = seq;
                           snd_unacked_in  = ack;
                           events.released = 1'b1;
                        end
                     end
                     ST_FIN_WAIT1: begin
                        if (fl_ack) begin
                           rcv_next_in    = seq;
                           snd_unacked_in = ack;
                        end
                     end
                     ST_FIN_WAIT2: begin
                        if (fl_fin) begin
                           rcv_next_in           = seq_inc;
                           snd_unacked_in        = ack;
                           events.send_flags     = SEND_ACK;
                           events.start_timewait = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         endcase
      end
   end

endmodule

[hw/rtl/tcp_connection_state_machine.sv]
`timescale 1ns / 1ps
// Single TCP connection state machine: one segment or host load per cycle
// while the response is not stalled, one response per item. A request
// transfer is held in an input register, resolved against the connection
// state and sequence registers in one pass and written to the response
// register, from which the response is offered; the block sustains one item
// per cycle while rsp_tready is high. The connection state updates as the
// item moves into the response register, so the next item always sees it.
// A stalled response holds back at most one further item in the input
// register. Depends on tcsm_pkg, tcsm_in_reg and tcsm_step.
module tcp_connection_state_machine #(
   parameter int SEQ_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // low to high: seg_flags, seg_seq, seg_seq_end, seg_ack, recv_window,
   // accept_full, load_state, zero padding
   input  logic [tcsm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // action
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // low to high: conn_state, send_flags, dropped, reset_seen, spawn_child,
   // wake_waiter, start_timewait, released, rcv_next, snd_unacked
   output logic [tcsm_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import tcsm_pkg::*;

   seg_item_type        req_item;
   seg_item_type        item;
   logic                item_valid;
   logic                move;

   conn_state_type      state_ff;
   conn_state_type      state_in;
   logic [SEQ_BITS-1:0] rcv_next_ff;
   logic [SEQ_BITS-1:0] rcv_next_in;
   logic [SEQ_BITS-1:0] snd_unacked_ff;
   logic [SEQ_BITS-1:0] snd_unacked_in;
   step_event_type      events;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;
   logic [RSP_TDATA_W-1:0]  rsp_data_in;

   assign req_item.action      = req_tuser;
   assign req_item.seg_flags   = req_tdata[5:0];
   assign req_item.seg_seq     = req_tdata[37:6];
   assign req_item.seg_seq_end = req_tdata[69:38];
   assign req_item.seg_ack     = req_tdata[101:70];
   assign req_item.recv_window = req_tdata[117:102];
   assign req_item.accept_full = req_tdata[118];
   assign req_item.load_state  = req_tdata[122:119];

   assign move = item_valid && (!rsp_valid_ff || rsp_tready);

   tcsm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .take       (move),
      .item_valid (item_valid),
      .item       (item)
   );

   tcsm_step #(
      .SEQ_BITS (SEQ_BITS)
   ) u_step (
      .item           (item),
      .state          (state_ff),
      .rcv_next       (rcv_next_ff),
      .snd_unacked    (snd_unacked_ff),
      .state_in       (state_in),
      .rcv_next_in    (rcv_next_in),
      .snd_unacked_in (snd_unacked_in),
      .events         (events)
   );

   assign rsp_data_in = {SEQ_FIELD_W'(snd_unacked_in), SEQ_FIELD_W'(rcv_next_in),
                         events.released, events.start_timewait, events.wake_waiter,
                         events.spawn_child, events.reset_seen, events.dropped,
                         events.send_flags, state_in};
   assign rsp_valid_in = move || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLOSED;
         rcv_next_ff    <= '0;
         snd_unacked_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (move) begin
            state_ff       <= state_in;
            rcv_next_ff    <= rcv_next_in;
            snd_unacked_ff <= snd_unacked_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_move_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_tvalid)
      else $error("item consumed without a response");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !move |=> $stable(state_ff) && $stable(rcv_next_ff) && $stable(snd_unacked_ff))
      else $error("connection state changed without an item");

   a_rst_closes: assert property (@(posedge clock) disable iff (reset)
      move && events.reset_seen |=> state_ff == ST_CLOSED)
      else $error("RST did not close the connection");

   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !move |=> !rsp_tvalid)
      else $error("response repeated after transfer");
`endif

endmodule
